[rtl/spi4_pkg.sv]
// Shared types and constants for the four-mode SPI master.
// Used by every module under rtl/; depends on nothing.
package spi4_pkg;

    localparam int MAX_BITS  = 16;
    localparam int BYTE_BITS = 8;
    localparam int DATA_W    = 16;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = $clog2(MAX_BITS + 1);

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_START   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] tx_data;
        logic              sixteen_bit;
        logic              keep_select;
        logic              miso;
    } item_t;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              select_n;
        logic [DATA_W-1:0] rx_data;
        logic              word_done;
        logic              rejected;
    } result_t;

    typedef struct packed {
        logic busy;
        logic count_zero;
        logic select_level;
    } core_status_t;

endpackage

[rtl/spi4_in_stage.sv]
// Input register for request items.
// Depends on spi4_pkg.
module spi4_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  spi4_pkg::item_t item_in,
    input  logic           advance,
    output logic           item_valid,
    output spi4_pkg::item_t item_out
);
    import spi4_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;
endmodule

[rtl/spi4_core.sv]
// Transfer state and next-state logic: shift registers, bit count, line levels.
// Depends on spi4_pkg.
module spi4_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [spi4_pkg::MODE_W-1:0] cfg_mode,
    input  logic                        step,
    input  spi4_pkg::item_t             item,
    output spi4_pkg::result_t           result,
    output spi4_pkg::core_status_t      status
);
    import spi4_pkg::*;

    logic [MODE_W-1:0]   mode_reg,     mode_next;
    logic [MAX_BITS-1:0] tx_reg,       tx_next;
    logic [DATA_W-1:0]   rx_reg,       rx_next;
    logic [COUNT_W-1:0]  count_reg,    count_next;
    logic                half_reg,     half_next;
    logic                busy_reg,     busy_next;
    logic                clock_reg,    clock_next;
    logic                data_reg,     data_next;
    logic                select_reg,   select_next;
    logic                hold_reg,     hold_next;
    logic                wide_reg,     wide_next;

    logic                cpol;
    logic                cpha;
    logic [MAX_BITS-1:0] tx_load;
    logic [MAX_BITS-1:0] tx_shifted;
    logic [DATA_W-1:0]   rx_sampled;
    logic [COUNT_W-1:0]  count_dec;
    logic                done;
    logic                rej;
    logic [DATA_W-1:0]   rx_out;

    // top bit of the active word, for the current and the freshly loaded word
    function automatic logic top_bit(input logic [MAX_BITS-1:0] w, input logic wide);
        top_bit = wide ? w[MAX_BITS-1] : w[BYTE_BITS-1];
    endfunction

    assign cpol       = mode_reg[1];
    assign cpha       = mode_reg[0];
    assign tx_load    = item.sixteen_bit ? MAX_BITS'(item.tx_data)
                                         : MAX_BITS'(item.tx_data[BYTE_BITS-1:0]);
    assign tx_shifted = {tx_reg[MAX_BITS-2:0], 1'b0};
    assign rx_sampled = {rx_reg[DATA_W-2:0], item.miso};
    assign count_dec  = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        count_next  = count_reg;
        half_next   = half_reg;
        busy_next   = busy_reg;
        clock_next  = clock_reg;
        data_next   = data_reg;
        select_next = select_reg;
        hold_next   = hold_reg;
        wide_next   = wide_reg;
        done        = 1'b0;
        rej         = 1'b0;
        rx_out      = '0;

        if (cfg_write)
        begin
            mode_next = cfg_mode;
            if (!busy_reg)
            begin
                clock_next = cfg_mode[1];
            end
        end

        if (step)
        begin
            unique case (kind_t'(item.kind))
                KIND_START:
                begin
                    if (busy_reg)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        wide_next   = item.sixteen_bit;
                        tx_next     = tx_load;
                        rx_next     = '0;
                        count_next  = item.sixteen_bit ? COUNT_W'(MAX_BITS)
                                                       : COUNT_W'(BYTE_BITS);
                        hold_next   = item.keep_select;
                        select_next = 1'b0;
                        busy_next   = 1'b1;
                        half_next   = 1'b0;
                        clock_next  = cpol;
                        if (!cpha)
                        begin
                            data_next = top_bit(tx_load, item.sixteen_bit);
                        end
                    end
                end
                KIND_RELEASE:
                begin
                    hold_next = 1'b0;
                    if (!busy_reg)
                    begin
                        select_next = 1'b1;
                    end
                end
                KIND_TICK:
                begin
                    if (busy_reg)
                    begin
                        clock_next = !clock_reg;
                        if (!half_reg)
                        begin
                            // leading edge
                            if (cpha)
                            begin
                                data_next = top_bit(tx_reg, wide_reg);
                                tx_next   = tx_shifted;
                            end
                            else
                            begin
                                rx_next = rx_sampled;
                            end
                            half_next = 1'b1;
                        end
                        else
                        begin
                            // trailing edge
                            if (cpha)
                            begin
                                rx_next = rx_sampled;
                            end
                            else
                            begin
                                tx_next = tx_shifted;
                            end
                            half_next  = 1'b0;
                            count_next = count_dec;
                            if (count_dec == '0)
                            begin
                                busy_next  = 1'b0;
                                done       = 1'b1;
                                rx_out     = wide_reg ? rx_next
                                                      : {{(DATA_W-BYTE_BITS){1'b0}},
                                                         rx_next[BYTE_BITS-1:0]};
                                clock_next = cpol;
                                if (!hold_reg)
                                begin
                                    select_next = 1'b1;
                                end
                            end
                            else if (!cpha)
                            begin
                                data_next = top_bit(tx_shifted, wide_reg);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            tx_reg     <= '0;
            rx_reg     <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            clock_reg  <= 1'b0;
            data_reg   <= 1'b0;
            select_reg <= 1'b1;
            hold_reg   <= 1'b0;
            wide_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
            busy_reg   <= busy_next;
            clock_reg  <= clock_next;
            data_reg   <= data_next;
            select_reg <= select_next;
            hold_reg   <= hold_next;
            wide_reg   <= wide_next;
        end
    end

    assign result.sclk      = clock_next;
    assign result.mosi      = data_next;
    assign result.select_n  = select_next;
    assign result.rx_data   = rx_out;
    assign result.word_done = done;
    assign result.rejected  = rej;

    assign status.busy         = busy_reg;
    assign status.count_zero   = (count_reg == '0);
    assign status.select_level = select_reg;
endmodule

[rtl/spi4_out_stage.sv]
// Result register toward the output channel.
// Depends on spi4_pkg.
module spi4_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  spi4_pkg::result_t result_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output spi4_pkg::result_t result_out
);
    import spi4_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;
endmodule

[rtl/spi_master_four_mode.sv]
// SPI master for 8- or 16-bit words, clock modes 0 to 3 (CPOL = spi_mode[1],
// CPHA = spi_mode[0]). Each request is a tick (one half SCLK period), a start,
// a release of select or a no-op; each yields exactly one result with the
// line levels after it. Throughput is one request per clock while out_ready is
// high; each request passes the input register, the single state update and
// the result register. Write spi_mode only while no request is in flight; a
// write in mid-word keeps the clock level and governs the remaining edges.
module spi_master_four_mode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [spi4_pkg::MODE_W-1:0] spi_mode,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [spi4_pkg::DATA_W-1:0] tx_data,
    input  logic                        sixteen_bit,
    input  logic                        keep_select,
    input  logic                        miso,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        sclk,
    output logic                        mosi,
    output logic                        select_n,
    output logic [spi4_pkg::DATA_W-1:0] rx_data,
    output logic                        word_done,
    output logic                        rejected
);
    import spi4_pkg::*;

    item_t        item_in;
    item_t        item_q;
    logic         item_valid;
    logic         can_load;
    logic         advance;
    result_t      result_d;
    result_t      result_q;
    core_status_t status;

    assign cfg_ready = 1'b1;

    assign item_in.kind        = kind;
    assign item_in.tx_data     = tx_data;
    assign item_in.sixteen_bit = sixteen_bit;
    assign item_in.keep_select = keep_select;
    assign item_in.miso        = miso;

    assign advance = item_valid && can_load;

    spi4_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    spi4_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_mode  (spi_mode),
        .step      (advance),
        .item      (item_q),
        .result    (result_d),
        .status    (status)
    );

    spi4_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (result_d),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_q)
    );

    assign sclk      = result_q.sclk;
    assign mosi      = result_q.mosi;
    assign select_n  = result_q.select_n;
    assign rx_data   = result_q.rx_data;
    assign word_done = result_q.word_done;
    assign rejected  = result_q.rejected;

    // an idle engine has no bits pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> status.count_zero)
        else $error("bit count nonzero while idle");

    // select stays asserted for the whole transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !status.select_level)
        else $error("select released during transfer");

    // a finished word ends the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_d.word_done |=> !status.busy)
        else $error("engine still busy after word end");

    // a result is never both a completion and a rejected start
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(word_done && rejected))
        else $error("word_done and rejected together");
endmodule

[tb/spi_master_four_mode_tb.sv]
// Self-checking testbench for spi_master_four_mode: queue-fed request driver,
// line-level predictor and scoreboard checker. Depends on rtl/spi4_pkg.sv and the DUT.
`timescale 1ns / 100ps

module spi_master_four_mode_tb;
    import spi4_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WORD_TARGET = 500;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        bit                is_cfg;
        bit                is_drain;
        logic [MODE_W-1:0] mode;
        item_t             it;
    } spi_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] spi_mode = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        kind = KIND_NOP;
    logic [DATA_W-1:0] tx_data = '0;
    logic              sixteen_bit = 1'b0;
    logic              keep_select = 1'b0;
    logic              miso = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              sclk;
    logic              mosi;
    logic              select_n;
    logic [DATA_W-1:0] rx_data;
    logic              word_done;
    logic              rejected;

    spi_req_t    spi_req_q[$];
    result_t     predicted_lines_q[$];
    int unsigned word_items = 0;
    int unsigned err_cnt = 0;
    int unsigned stall_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    int unsigned seg_left = 0;
    int unsigned seg_kind = 0;
    int unsigned seg_phase = 0;
    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;

    // predictor state
    logic [MODE_W-1:0]  cur_mode;
    logic [DATA_W-1:0]  sh_tx;
    logic [DATA_W-1:0]  sh_rx;
    logic [COUNT_W-1:0] bits_rem;
    logic               half2;
    logic               xfer_busy;
    logic               lvl_clk;
    logic               lvl_mosi;
    logic               lvl_sel;
    logic               keep_low;
    logic               wide_xfer;

    spi_master_four_mode dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .spi_mode   (spi_mode),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .tx_data    (tx_data),
        .sixteen_bit(sixteen_bit),
        .keep_select(keep_select),
        .miso       (miso),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sclk       (sclk),
        .mosi       (mosi),
        .select_n   (select_n),
        .rx_data    (rx_data),
        .word_done  (word_done),
        .rejected   (rejected)
    );

    always #1 clk = ~clk;

    function automatic logic tx_msb();
        return wide_xfer ? sh_tx[MAX_BITS-1] : sh_tx[BYTE_BITS-1];
    endfunction

    // Advance the line model by one request and return the levels after it.
    function automatic result_t spi_line_step(item_t it);
        result_t r;
        logic    cpol;
        logic    cpha;
        cpol = cur_mode[1];
        cpha = cur_mode[0];
        r = '0;
        case (it.kind)
            KIND_START:
                if (xfer_busy) begin
                    r.rejected = 1'b1;
                end else begin
                    wide_xfer = it.sixteen_bit;
                    sh_tx = it.tx_data;
                    if (!it.sixteen_bit)
                        sh_tx[DATA_W-1:BYTE_BITS] = '0;
                    sh_rx = '0;
                    bits_rem = it.sixteen_bit ? COUNT_W'(MAX_BITS) : COUNT_W'(BYTE_BITS);
                    keep_low = it.keep_select;
                    lvl_sel = 1'b0;
                    xfer_busy = 1'b1;
                    half2 = 1'b0;
                    lvl_clk = cpol;
                    if (!cpha)
                        lvl_mosi = tx_msb();
                end
            KIND_RELEASE:
            begin
                keep_low = 1'b0;
                if (!xfer_busy)
                    lvl_sel = 1'b1;
            end
            KIND_TICK:
                if (xfer_busy) begin
                    lvl_clk = ~lvl_clk;
                    if (!half2) begin
                        if (cpha) begin
                            lvl_mosi = tx_msb();
                            sh_tx = sh_tx << 1;
                        end else begin
                            sh_rx = {sh_rx[DATA_W-2:0], it.miso};
                        end
                        half2 = 1'b1;
                    end else begin
                        if (cpha)
                            sh_rx = {sh_rx[DATA_W-2:0], it.miso};
                        else
                            sh_tx = sh_tx << 1;
                        half2 = 1'b0;
                        if (bits_rem != 0)
                            bits_rem = bits_rem - 1'b1;
                        if (bits_rem == 0) begin
                            xfer_busy = 1'b0;
                            r.word_done = 1'b1;
                            r.rx_data = sh_rx;
                            if (!wide_xfer)
                                r.rx_data[DATA_W-1:BYTE_BITS] = '0;
                            lvl_clk = cpol;
                            if (!keep_low)
                                lvl_sel = 1'b1;
                        end else if (!cpha) begin
                            lvl_mosi = tx_msb();
                        end
                    end
                end
            default: ;
        endcase
        r.sclk = lvl_clk;
        r.mosi = lvl_mosi;
        r.select_n = lvl_sel;
        return r;
    endfunction

    task automatic push_item(input logic [1:0] k, input logic [DATA_W-1:0] d,
                             input logic w, input logic ke, input logic mi);
        spi_req_t q;
        q.is_cfg = 1'b0;
        q.is_drain = 1'b0;
        q.mode = '0;
        q.it = {k, d, w, ke, mi};
        spi_req_q.push_back(q);
    endtask

    task automatic push_cfg(input logic [MODE_W-1:0] m);
        spi_req_t q;
        q.is_cfg = 1'b1;
        q.is_drain = 1'b0;
        q.mode = m;
        q.it = '0;
        spi_req_q.push_back(q);
    endtask

    task automatic push_drain();
        spi_req_t q;
        q.is_cfg = 1'b0;
        q.is_drain = 1'b1;
        q.mode = '0;
        q.it = '0;
        spi_req_q.push_back(q);
    endtask

    // Random junk on the unused fields of a tick.
    task automatic push_tick(input logic mi);
        push_item(KIND_TICK, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), mi);
    endtask

    task automatic push_noise();
        push_item(2'($urandom_range(0, 3)), DATA_W'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // One start plus its ticks, with occasional requests mixed in mid-word.
    task automatic push_word();
        int unsigned       nticks;
        int unsigned       i;
        logic              wide;
        logic              keep;
        logic [DATA_W-1:0] d;
        wide = 1'($urandom_range(0, 1));
        keep = 1'($urandom_range(0, 1));
        d = DATA_W'($urandom);
        case ($urandom_range(0, 7))
            0: d = '0;
            1: d = '1;
            default: ;
        endcase
        nticks = wide ? 2 * MAX_BITS : 2 * BYTE_BITS;
        if ($urandom_range(0, 9) == 0)
            nticks = $urandom_range(0, nticks - 1);   // cut short
        push_item(KIND_START, d, wide, keep, 1'($urandom_range(0, 1)));
        for (i = 0; i < nticks; i++) begin
            case ($urandom_range(0, 49))
                0: push_item(KIND_RELEASE, DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
                1: push_item(KIND_START, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b0);
                2: push_item(KIND_NOP, DATA_W'($urandom), 1'b1, 1'b1, 1'b1);
                3: push_cfg(MODE_W'($urandom_range(0, 3)));
                default: ;
            endcase
            push_tick(1'($urandom_range(0, 1)));
        end
        word_items += nticks + 1;
        if (keep && $urandom_range(0, 1) == 1)
            push_item(KIND_RELEASE, DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // request driver: one update of each handshake signal per falling edge
    always @(negedge clk) begin : drive
        logic     nv;
        logic     nc;
        spi_req_t head;
        nv = in_valid;
        nc = cfg_valid;
        if (in_taken)
            nv = 1'b0;
        if (cfg_taken)
            nc = 1'b0;
        if (rst_n && !nv && !nc) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
            end else if (spi_req_q.size() != 0) begin
                head = spi_req_q[0];
                if (head.is_cfg || head.is_drain) begin
                    // mode writes and pauses wait for every result to come back
                    if (predicted_lines_q.size() == 0) begin
                        void'(spi_req_q.pop_front());
                        if (head.is_cfg) begin
                            nc = 1'b1;
                            spi_mode <= head.mode;
                        end
                    end
                end else begin
                    void'(spi_req_q.pop_front());
                    nv = 1'b1;
                    kind <= head.it.kind;
                    tx_data <= head.it.tx_data;
                    sixteen_bit <= head.it.sixteen_bit;
                    keep_select <= head.it.keep_select;
                    miso <= head.it.miso;
                    if (burst_left > 1) begin
                        burst_left = burst_left - 1;
                    end else if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                        burst_left = $urandom_range(30, 80);
                    end else begin
                        gap_left = $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 10);
                    end
                end
            end
        end
        in_valid <= nv;
        cfg_valid <= nc;
    end

    // result-side backpressure in segments of differing character
    always @(negedge clk) begin : stall_pattern
        logic rdy;
        if (seg_left == 0) begin
            seg_kind = $urandom_range(0, 3);
            seg_left = $urandom_range(10, 100);
        end
        seg_left = seg_left - 1;
        seg_phase = seg_phase + 1;
        case (seg_kind)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (seg_phase % 3 == 0);
        endcase
        out_ready <= rdy;
    end

    always @(posedge clk) begin : check
        result_t want;
        result_t got;
        item_t   req;
        if (!rst_n) begin
            cur_mode = '0;
            sh_tx = '0;
            sh_rx = '0;
            bits_rem = '0;
            half2 = 1'b0;
            xfer_busy = 1'b0;
            lvl_clk = 1'b0;
            lvl_mosi = 1'b0;
            lvl_sel = 1'b1;
            keep_low = 1'b0;
            wide_xfer = 1'b0;
            in_taken <= 1'b0;
            cfg_taken <= 1'b0;
            stall_cycles = 0;
        end else begin
            in_taken <= in_valid && in_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                cur_mode = spi_mode;
                if (!xfer_busy)
                    lvl_clk = spi_mode[1];
            end
            if (in_valid && in_ready) begin
                req = {kind, tx_data, sixteen_bit, keep_select, miso};
                predicted_lines_q.push_back(spi_line_step(req));
            end
            if (out_valid && out_ready) begin
                got = {sclk, mosi, select_n, rx_data, word_done, rejected};
                if (predicted_lines_q.size() == 0) begin
                    note_error($sformatf("unexpected result: sclk=%0b mosi=%0b sel=%0b rx=%h done=%0b rej=%0b",
                                         got.sclk, got.mosi, got.select_n, got.rx_data,
                                         got.word_done, got.rejected));
                end else begin
                    want = predicted_lines_q.pop_front();
                    if (want.sclk !== got.sclk || want.mosi !== got.mosi ||
                        want.select_n !== got.select_n || want.rx_data !== got.rx_data ||
                        want.word_done !== got.word_done || want.rejected !== got.rejected)
                        note_error($sformatf({"mismatch: exp sclk=%0b mosi=%0b sel=%0b rx=%h ",
                                              "done=%0b rej=%0b, got sclk=%0b mosi=%0b sel=%0b ",
                                              "rx=%h done=%0b rej=%0b"},
                                             want.sclk, want.mosi, want.select_n, want.rx_data,
                                             want.word_done, want.rejected,
                                             got.sclk, got.mosi, got.select_n, got.rx_data,
                                             got.word_done, got.rejected));
                end
            end
            if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned sel;

        // directed: idle requests, held frame, busy start, busy mode change
        push_cfg(2'd3);                                   // idle clock follows CPOL
        push_item(KIND_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1);  // tick while idle
        push_item(KIND_RELEASE, 16'h0000, 1'b0, 1'b0, 1'b0);
        push_item(KIND_NOP, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        push_item(KIND_START, 16'hFF5A, 1'b0, 1'b1, 1'b0); // byte word, select held
        for (i = 0; i < 2 * BYTE_BITS; i++) begin
            if (i == 3)
                push_item(KIND_START, 16'hFFFF, 1'b1, 1'b0, 1'b1);  // rejected
            if (i == 8)
                push_cfg(2'd1);                           // mode change mid-word
            push_item(KIND_TICK, 16'h0000, 1'b0, 1'b0, 1'((i % 3) == 0));
        end
        push_item(KIND_RELEASE, 16'h0000, 1'b0, 1'b0, 1'b0);  // ends the held frame
        push_cfg(2'd0);

        while (word_items < WORD_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                push_cfg(MODE_W'($urandom_range(0, 3)));
            else if (sel < 12)
                push_drain();
            else if (sel < 22)
                repeat ($urandom_range(1, 4)) push_noise();
            else
                push_word();
        end
        push_cfg(2'd3);
        push_word();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (spi_req_q.size() != 0 || in_valid || cfg_valid || predicted_lines_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/spi4_pkg.sv
rtl/spi4_in_stage.sv
rtl/spi4_core.sv
rtl/spi4_out_stage.sv
rtl/spi_master_four_mode.sv
tb/spi_master_four_mode_tb.sv
